>>> hdl/cdq_pkg.sv
// Package for the circular deque: default depth, opcodes, result status codes
// and control states.
// No dependencies.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;

  typedef enum logic [2:0] {
    OP_DISPLAY    = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DISP
  } state_t;

endpackage

`default_nettype wire

>>> hdl/circular_deque.sv
// Top level of the circular deque: ring memory, front and rear pointers,
// fill count and result sequencer.
// Depends on cdq_pkg.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+---------------------------
//   input   | in_opcode, in_data_in                  | start high, busy low
//   result  | out_status, out_data_out, out_last     | out_strobe, one cycle each
//
// Push, a refused push and a pop or display on an empty ring: result in the cycle
// after acceptance, busy stays low.
// Pop: the ring read is registered in rd_q, then in the result registers.
// Display: one ring read per result; busy stays high through S_DISP.
// Reset clears pointers, count, state and strobe; the ring itself is not cleared.
// The receiver cannot stall; results are never held back.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               in_opcode,
  input  wire logic signed [DATA_W-1:0] in_data_in,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_data_out,
  output logic                          out_last
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  logic [DATA_W-1:0] ring [DEPTH];
  logic [DATA_W-1:0] rd_q;

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  front_r, front_nxt;
  logic [PTR_W-1:0]  rear_r, rear_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  disp_left_r, disp_left_nxt;
  logic [PTR_W-1:0]  rd_addr_r, rd_addr_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;

  logic              accept;
  logic              ring_empty;
  logic              ring_full;

  assign accept     = start && (state_r == S_IDLE);
  assign ring_empty = (count_r == '0);
  assign ring_full  = (count_r == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= in_data_in;
    end
    if (mem_re) begin
      rd_q <= ring[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      rear_r       <= '0;
      count_r      <= '0;
      disp_left_r  <= '0;
      rd_addr_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      rear_r       <= rear_nxt;
      count_r      <= count_nxt;
      disp_left_r  <= disp_left_nxt;
      rd_addr_r    <= rd_addr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    count_nxt      = count_r;
    disp_left_nxt  = disp_left_r;
    rd_addr_nxt    = rd_addr_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = front_r;
    mem_re         = 1'b0;
    mem_raddr      = front_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (opcode_t'(in_opcode))
            OP_DISPLAY: begin
              if (ring_empty) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_data_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                mem_re        = 1'b1;
                mem_raddr     = front_r;
                rd_addr_nxt   = ptr_next(front_r);
                disp_left_nxt = count_r;
                state_nxt     = S_DISP;
              end
            end
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '0;
              out_last_nxt   = 1'b1;
              if (ring_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                mem_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
                if (ring_empty) begin
                  front_nxt = '0;
                  rear_nxt  = '0;
                  mem_waddr = '0;
                end else if (opcode_t'(in_opcode) == OP_PUSH_FRONT) begin
                  front_nxt = ptr_prev(front_r);
                  mem_waddr = ptr_prev(front_r);
                end else begin
                  rear_nxt  = ptr_next(rear_r);
                  mem_waddr = ptr_next(rear_r);
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (ring_empty) begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_data_nxt   = '0;
                out_last_nxt   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                count_nxt = count_r - 1'b1;
                state_nxt = S_POP;
                if (opcode_t'(in_opcode) == OP_POP_FRONT) begin
                  mem_raddr = front_r;
                  if (count_r != CNT_W'(1)) begin
                    front_nxt = ptr_next(front_r);
                  end
                end else begin
                  mem_raddr = rear_r;
                  if (count_r != CNT_W'(1)) begin
                    rear_nxt = ptr_prev(rear_r);
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = ST_OK;
        out_data_nxt   = rd_q;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DISP: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = ST_OK;
        out_data_nxt   = rd_q;
        out_last_nxt   = (disp_left_r == CNT_W'(1));
        mem_re         = 1'b1;
        mem_raddr      = rd_addr_r;
        rd_addr_nxt    = ptr_next(rd_addr_r);
        disp_left_nxt  = disp_left_r - 1'b1;
        if (disp_left_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy         = (state_r != S_IDLE);
  assign out_strobe   = out_strobe_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_disp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP && disp_left_r == CNT_W'(1)) |=> (out_strobe && out_last))
    else $error("display run not closed with last");

  a_nonlast_disp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |-> (state_r == S_DISP))
    else $error("non-final result outside a display run");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ring_full &&
     (in_opcode == OP_PUSH_FRONT || in_opcode == OP_PUSH_REAR))
    |=> (count_r == $past(count_r) + 1'b1))
    else $error("accepted push did not advance count");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> (out_last && out_data_out == '0))
    else $error("full or empty result carries data");

endmodule

`default_nettype wire

>>> test/circular_deque_tb.sv
`timescale 1ns / 100ps
// Testbench for circular_deque: directed empty, full and wrap cases, then random
// push, pop and display traffic checked against a shadow deque kept in the bench.
// Depends on cdq_pkg and circular_deque.

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int DRAIN_CYCLES = DEPTH + 4;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } deque_result_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     start      = 1'b0;
  logic [2:0]               in_opcode  = OP_DISPLAY;
  logic signed [DATA_W-1:0] in_data_in = '0;
  logic                     busy;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_data_out;
  logic                     out_last;

  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  int                       shadow_front = 0;
  int                       shadow_rear  = 0;
  int                       shadow_count = 0;
  deque_result_t            pending_results [$];
  int                       transactions_sent = 0;
  int                       results_checked   = 0;
  int                       mismatches        = 0;

  circular_deque i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_data_in  (in_data_in),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_data_out(out_data_out),
    .out_last    (out_last)
  );

  always #5 clk = ~clk;

  function automatic void expect_result(status_t st, logic signed [DATA_W-1:0] d, logic lst);
    deque_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void update_shadow_deque(logic [2:0] op, logic signed [DATA_W-1:0] word);
    int slot;
    case (op)
      OP_DISPLAY: begin
        if (shadow_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          slot = shadow_front;
          for (int n = 0; n < shadow_count; n++) begin
            expect_result(ST_OK, shadow_ring[slot], n == shadow_count - 1);
            slot = (slot == DEPTH - 1) ? 0 : slot + 1;
          end
        end
      end
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (shadow_count >= DEPTH) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          if (shadow_count == 0) begin
            shadow_front   = 0;
            shadow_rear    = 0;
            shadow_ring[0] = word;
          end else if (op == OP_PUSH_FRONT) begin
            shadow_front              = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
            shadow_ring[shadow_front] = word;
          end else begin
            shadow_rear              = (shadow_rear == DEPTH - 1) ? 0 : shadow_rear + 1;
            shadow_ring[shadow_rear] = word;
          end
          shadow_count++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (shadow_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else if (op == OP_POP_FRONT) begin
          expect_result(ST_OK, shadow_ring[shadow_front], 1'b1);
          if (shadow_count > 1) shadow_front = (shadow_front == DEPTH - 1) ? 0 : shadow_front + 1;
          shadow_count--;
        end else begin
          expect_result(ST_OK, shadow_ring[shadow_rear], 1'b1);
          if (shadow_count > 1) shadow_rear = (shadow_rear == 0) ? DEPTH - 1 : shadow_rear - 1;
          shadow_count--;
        end
      end
      default: ;
    endcase
  endfunction

  // hold the transaction until the block takes it
  task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] word);
    @(negedge clk);
    start      <= 1'b1;
    in_opcode  <= op;
    in_data_in <= word;
    do @(posedge clk); while (busy);
    update_shadow_deque(op, word);
    transactions_sent++;
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained;
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -32'sd1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data_out %0d last %0b",
               out_status, out_data_out, out_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
        if (out_data_out !== want.data) begin
          $error("data_out: expected %0d, actual %0d", want.data, out_data_out);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_empty_ring;
    send_item(OP_DISPLAY, 32'sh1234_5678);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_REAR, '0);
    send_item(OP_RSVD5, -32'sd1);
    send_item(OP_RSVD6, '0);
    send_item(OP_RSVD7, 32'sh7fff_ffff);
  endtask

  task automatic test_fill_to_full;
    send_item(OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(OP_PUSH_FRONT, 32'sh7fff_ffff);
    send_item(OP_PUSH_REAR, -32'sd1);
    send_item(OP_PUSH_REAR, '0);
    send_item(OP_PUSH_FRONT, 32'sh5555_5555);
    send_item(OP_PUSH_REAR, 32'shaaaa_aaaa);
    send_item(OP_PUSH_FRONT, 32'sd1);
    send_item(OP_PUSH_REAR, $urandom);
    send_item(OP_PUSH_FRONT, 32'sh0bad_f00d);
    send_item(OP_PUSH_REAR, 32'sh0bad_f00d);
    send_item(OP_DISPLAY, '0);
  endtask

  task automatic test_drain_to_empty;
    for (int k = 0; k < DEPTH; k++) begin
      send_item((k % 2 == 0) ? OP_POP_FRONT : OP_POP_REAR, $urandom);
    end
  endtask

  // random walk that swings between filling and emptying the ring
  task automatic test_random_traffic(input int n, input bit idling);
    int         done;
    int         r;
    bit         push_bias;
    logic [2:0] op;
    done = 0;
    while (done < n) begin
      push_bias = ($urandom_range(0, 1) == 1) ? ((done / 24) % 2 == 0) : push_bias;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
      end else if (r < 14) begin
        op = OP_DISPLAY;
      end else if (r < (push_bias ? 75 : 38)) begin
        op = ($urandom_range(0, 1) == 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      end else begin
        op = ($urandom_range(0, 1) == 1) ? OP_POP_FRONT : OP_POP_REAR;
      end
      send_item(op, pick_word());
      if (op < OP_RSVD5) done++;
      if (idling && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_ring();
    test_fill_to_full();
    test_drain_to_empty();
    test_random_traffic(100, 1'b1);
    wait_drained();
    test_random_traffic(100, 1'b1);
    test_random_traffic(50, 1'b0);
    wait_drained();

    $display("%0d transactions sent, %0d results checked, %0d mismatches",
             transactions_sent, results_checked, mismatches);
    $display("Covered empty and full refusals, pointer wrap, display of 0 to %0d words, "
             , DEPTH, "reserved opcodes and random idling");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS circular_deque");
    end else begin
      $display("FAIL circular_deque");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL circular_deque");
    $finish;
  end

endmodule

>>> circular_deque.f
hdl/cdq_pkg.sv
hdl/circular_deque.sv
test/circular_deque_tb.sv
